### rtl/core/delayed_task_dispatch_table_assert.svh
// Assertion macros used by the dispatch table checker.
`ifndef DELAYED_TASK_DISPATCH_TABLE_ASSERT_SVH
`define DELAYED_TASK_DISPATCH_TABLE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define DTDT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dispatch table assertion failed");

// Next-cycle implication, held off during reset.
`define DTDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dispatch table assertion failed");

`endif

### rtl/core/dtdt_pkg.sv
// Shared types and constants for the delayed task dispatch table.
`default_nettype none
package dtdt_pkg;

   localparam int DTDT_QUEUE_DEPTH   = 16;
   localparam int DTDT_DELAY_WIDTH   = 16;
   localparam int DTDT_TASK_ID_WIDTH = 8;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_CLEAR,
      ST_DEC,
      ST_FIRE,
      ST_SHIFT,
      ST_RESP
   } dtdt_state_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_ADD,
      CMD_CLEAR,
      CMD_DEC,
      CMD_FIRE,
      CMD_SHIFT,
      CMD_RESP
   } dtdt_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic expired;
      logic found;
   } dtdt_status_type;

endpackage
`default_nettype wire

### rtl/core/dtdt_ctrl.sv
// Sequencing state machine of the delayed task dispatch table.
`default_nettype none
module dtdt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_operation,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  dtdt_pkg::dtdt_status_type status,
   output dtdt_pkg::dtdt_cmd_type    cmd
);
   import dtdt_pkg::*;

   dtdt_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation)
                  OP_ADD:   state_in = ST_ADD;
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_TICK:  state_in = ST_DEC;
                  default:  state_in = ST_RESP;
               endcase
            end
         end
         ST_ADD: state_in = ST_RESP;
         ST_CLEAR: begin
            if (status.scan_done) state_in = ST_RESP;
         end
         ST_DEC: begin
            if (status.scan_done) state_in = ST_FIRE;
         end
         ST_FIRE: begin
            if (status.expired && status.found) state_in = ST_SHIFT;
            else state_in = ST_RESP;
         end
         ST_SHIFT: begin
            if (status.scan_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd = CMD_LOAD;
         end
         ST_ADD:   cmd = CMD_ADD;
         ST_CLEAR: cmd = CMD_CLEAR;
         ST_DEC:   cmd = CMD_DEC;
         ST_FIRE:  cmd = CMD_FIRE;
         ST_SHIFT: cmd = CMD_SHIFT;
         ST_RESP: begin
            if (rsp_free) cmd = CMD_RESP;
         end
         default: cmd = CMD_NONE;
      endcase
      if (cmd == CMD_RESP) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### rtl/core/dtdt_dpath.sv
// Entry memory, scan pointers and result register of the dispatch table.
`default_nettype none
module dtdt_dpath #(
   parameter int QUEUE_DEPTH   = dtdt_pkg::DTDT_QUEUE_DEPTH,
   parameter int DELAY_WIDTH   = dtdt_pkg::DTDT_DELAY_WIDTH,
   parameter int TASK_ID_WIDTH = dtdt_pkg::DTDT_TASK_ID_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dtdt_pkg::dtdt_cmd_type                 cmd,
   output dtdt_pkg::dtdt_status_type              status,
   input  logic [1:0]                             req_operation,
   input  logic [TASK_ID_WIDTH-1:0]               req_task_id,
   input  logic [DELAY_WIDTH-1:0]                 req_delay,
   output logic                                   rsp_accepted,
   output logic                                   rsp_fired,
   output logic [TASK_ID_WIDTH-1:0]               rsp_fired_task,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]       rsp_cleared_count
);
   import dtdt_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [TASK_ID_WIDTH-1:0] task_mem  [QUEUE_DEPTH];
   logic [DELAY_WIDTH-1:0]   delay_mem [QUEUE_DEPTH];
   logic [TASK_ID_WIDTH-1:0] rd_task_ff;
   logic [DELAY_WIDTH-1:0]   rd_delay_ff;

   logic [CW-1:0]            count_ff, count_in;
   logic                     expired_ff, expired_in;
   logic [CW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic                     pend_ff, pend_in;
   logic [1:0]               op_ff, op_in;
   logic [TASK_ID_WIDTH-1:0] id_ff, id_in;
   logic [DELAY_WIDTH-1:0]   dly_ff, dly_in;
   logic                     add_ok_ff, add_ok_in;
   logic [CW-1:0]            clr_cnt_ff, clr_cnt_in;
   logic                     found_ff, found_in;
   logic [CW-1:0]            pos_ff, pos_in;
   logic                     fire_ff, fire_in;
   logic [TASK_ID_WIDTH-1:0] fire_task_ff, fire_task_in;
   logic                     rsp_acc_ff, rsp_acc_in;
   logic                     rsp_fired_ff, rsp_fired_in;
   logic [TASK_ID_WIDTH-1:0] rsp_task_ff, rsp_task_in;
   logic [CW-1:0]            rsp_cnt_ff, rsp_cnt_in;

   logic                     issue, scan_done, scanning, rd_en;
   logic                     wr_en;
   logic [IW-1:0]            wr_addr;
   logic [TASK_ID_WIDTH-1:0] wr_task;
   logic [DELAY_WIDTH-1:0]   wr_delay;

   assign issue     = rd_ptr_ff < count_ff;
   assign scan_done = !issue && !pend_ff;
   assign scanning  = (cmd == CMD_CLEAR) || (cmd == CMD_DEC) || (cmd == CMD_SHIFT);

   always_comb begin
      count_in     = count_ff;
      expired_in   = expired_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      pend_in      = pend_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      dly_in       = dly_ff;
      add_ok_in    = add_ok_ff;
      clr_cnt_in   = clr_cnt_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      fire_in      = fire_ff;
      fire_task_in = fire_task_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_fired_in = rsp_fired_ff;
      rsp_task_in  = rsp_task_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = wr_ptr_ff[IW-1:0];
      wr_task      = rd_task_ff;
      wr_delay     = rd_delay_ff;

      // issue the next read of a scan; data lands in the read register in the following cycle
      if (scanning) begin
         rd_en   = issue;
         pend_in = issue;
         if (issue) rd_ptr_in = rd_ptr_ff + CW'(1);
      end

      unique case (cmd)
         CMD_NONE: begin
         end
         CMD_LOAD: begin
            op_in      = req_operation;
            id_in      = req_task_id;
            dly_in     = req_delay;
            rd_ptr_in  = '0;
            wr_ptr_in  = '0;
            pend_in    = 1'b0;
            add_ok_in  = 1'b0;
            clr_cnt_in = '0;
            found_in   = 1'b0;
            fire_in    = 1'b0;
         end
         CMD_ADD: begin
            if (id_ff != '0 && dly_ff != '0 && count_ff < CW'(QUEUE_DEPTH)) begin
               wr_en     = 1'b1;
               wr_addr   = count_ff[IW-1:0];
               wr_task   = id_ff;
               wr_delay  = dly_ff;
               count_in  = count_ff + CW'(1);
               add_ok_in = 1'b1;
            end
         end
         CMD_CLEAR: begin
            // compact survivors toward the head
            if (pend_ff) begin
               if (rd_task_ff == id_ff) begin
                  clr_cnt_in = clr_cnt_ff + CW'(1);
               end else begin
                  wr_en     = 1'b1;
                  wr_ptr_in = wr_ptr_ff + CW'(1);
               end
            end
            if (scan_done) count_in = wr_ptr_ff;
         end
         CMD_DEC: begin
            if (pend_ff) begin
               wr_en     = 1'b1;
               wr_ptr_in = wr_ptr_ff + CW'(1);
               if (rd_delay_ff != '0) wr_delay = rd_delay_ff - DELAY_WIDTH'(1);
               else expired_in = 1'b1;
               if (rd_delay_ff[DELAY_WIDTH-1:1] == '0 && !found_ff) begin
                  found_in     = 1'b1;
                  pos_in       = wr_ptr_ff;
                  fire_task_in = rd_task_ff;
               end
            end
         end
         CMD_FIRE: begin
            if (expired_ff && found_ff) begin
               fire_in   = 1'b1;
               rd_ptr_in = pos_ff + CW'(1);
               wr_ptr_in = pos_ff;
               pend_in   = 1'b0;
            end else begin
               expired_in = 1'b0;
            end
         end
         CMD_SHIFT: begin
            if (pend_ff) begin
               wr_en     = 1'b1;
               wr_ptr_in = wr_ptr_ff + CW'(1);
            end
            if (scan_done) count_in = count_ff - CW'(1);
         end
         CMD_RESP: begin
            rsp_acc_in   = (op_ff == OP_ADD) ? add_ok_ff
                                             : (op_ff == OP_CLEAR || op_ff == OP_TICK);
            rsp_fired_in = fire_ff;
            rsp_task_in  = fire_ff ? fire_task_ff : '0;
            rsp_cnt_in   = clr_cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         task_mem[wr_addr]  <= wr_task;
         delay_mem[wr_addr] <= wr_delay;
      end
      if (rd_en) begin
         rd_task_ff  <= task_mem[rd_ptr_ff[IW-1:0]];
         rd_delay_ff <= delay_mem[rd_ptr_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         expired_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         count_ff   <= count_in;
         expired_ff <= expired_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      op_ff        <= op_in;
      id_ff        <= id_in;
      dly_ff       <= dly_in;
      add_ok_ff    <= add_ok_in;
      clr_cnt_ff   <= clr_cnt_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      fire_ff      <= fire_in;
      fire_task_ff <= fire_task_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   assign status.scan_done = scan_done;
   assign status.expired   = expired_ff;
   assign status.found     = found_ff;

   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_fired         = rsp_fired_ff;
   assign rsp_fired_task    = rsp_task_ff;
   assign rsp_cleared_count = rsp_cnt_ff;

endmodule
`default_nettype wire

### rtl/core/delayed_task_dispatch_table.sv
// Top level of the delayed task dispatch table.
// Ordered table of up to QUEUE_DEPTH one-shot tasks kept in a single-port-write,
// registered-read memory, one beat in and one beat out per operation. A clear
// sweeps the table one entry per cycle. A tick makes a decrement sweep and,
// when a task fires, a compaction sweep over the entries behind it. The
// memory's one read port sets the one-entry-per-cycle pace. The next request
// is taken once the previous result sits in the output register, even if not
// yet collected.
`default_nettype none
module delayed_task_dispatch_table #(
   parameter int QUEUE_DEPTH   = dtdt_pkg::DTDT_QUEUE_DEPTH,
   parameter int DELAY_WIDTH   = dtdt_pkg::DTDT_DELAY_WIDTH,
   parameter int TASK_ID_WIDTH = dtdt_pkg::DTDT_TASK_ID_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_operation,
   input  logic [TASK_ID_WIDTH-1:0]         req_task_id,
   input  logic [DELAY_WIDTH-1:0]           req_delay,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_accepted,
   output logic                             rsp_fired,
   output logic [TASK_ID_WIDTH-1:0]         rsp_fired_task,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] rsp_cleared_count
);
   import dtdt_pkg::*;

   dtdt_cmd_type    cmd;
   dtdt_status_type status;

   dtdt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   dtdt_dpath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .DELAY_WIDTH   (DELAY_WIDTH),
      .TASK_ID_WIDTH (TASK_ID_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_task_id       (req_task_id),
      .req_delay         (req_delay),
      .rsp_accepted      (rsp_accepted),
      .rsp_fired         (rsp_fired),
      .rsp_fired_task    (rsp_fired_task),
      .rsp_cleared_count (rsp_cleared_count)
   );

endmodule
`default_nettype wire

### rtl/core/dtdt_checker.sv
// Port-level assertions for the delayed task dispatch table, bound to the top level.
`default_nettype none
`include "delayed_task_dispatch_table_assert.svh"
module dtdt_checker #(
   parameter int QUEUE_DEPTH   = dtdt_pkg::DTDT_QUEUE_DEPTH,
   parameter int TASK_ID_WIDTH = dtdt_pkg::DTDT_TASK_ID_WIDTH
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_accepted,
   input logic                             rsp_fired,
   input logic [TASK_ID_WIDTH-1:0]         rsp_fired_task,
   input logic [$clog2(QUEUE_DEPTH+1)-1:0] rsp_cleared_count
);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   `DTDT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_accepted) && $stable(rsp_fired)
      && $stable(rsp_fired_task) && $stable(rsp_cleared_count))
   `DTDT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `DTDT_ASSERT_SAME(a_fire_shape, clock, reset, rsp_valid,
      rsp_fired ? (rsp_accepted && rsp_fired_task != '0 && rsp_cleared_count == '0)
                : (rsp_fired_task == '0))
   `DTDT_ASSERT_SAME(a_clear_shape, clock, reset, rsp_valid && rsp_cleared_count != '0,
      rsp_accepted && !rsp_fired && rsp_cleared_count <= CW'(QUEUE_DEPTH))

endmodule

bind delayed_task_dispatch_table dtdt_checker #(
   .QUEUE_DEPTH   (QUEUE_DEPTH),
   .TASK_ID_WIDTH (TASK_ID_WIDTH)
) u_dtdt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_accepted      (rsp_accepted),
   .rsp_fired         (rsp_fired),
   .rsp_fired_task    (rsp_fired_task),
   .rsp_cleared_count (rsp_cleared_count)
);
`default_nettype wire

### tb/tb_delayed_task_dispatch_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for the delayed task dispatch table.
module tb_delayed_task_dispatch_table;
   import dtdt_pkg::*;

   localparam int DEPTH = DTDT_QUEUE_DEPTH;
   localparam int DW = DTDT_DELAY_WIDTH;
   localparam int IW = DTDT_TASK_ID_WIDTH;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]    op;
      logic [IW-1:0] id;
      logic [DW-1:0] delay;
      bit            quiet;
   } task_cmd_type;

   typedef struct {
      logic          accepted;
      logic          fired;
      logic [IW-1:0] fired_task;
      logic [CW-1:0] cleared;
   } outcome_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [1:0]    req_operation = '0;
   logic [IW-1:0] req_task_id = '0;
   logic [DW-1:0] req_delay = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_accepted;
   logic          rsp_fired;
   logic [IW-1:0] rsp_fired_task;
   logic [CW-1:0] rsp_cleared_count;

   task_cmd_type task_cmd_q[$];
   outcome_type  outcome_q[$];
   task_cmd_type drv_cmd;
   outcome_type  want;
   int        req_issue_cnt = 0;
   int        req_accept_cnt = 0;
   int        req_gap = 0;
   int        rsp_stall = 0;
   bit        quiet_phase = 1'b0;
   int        mismatch_count = 0;

   logic [IW-1:0] shadow_task [DEPTH];
   logic [DW-1:0] shadow_delay [DEPTH];
   int            shadow_count = 0;
   bit            shadow_expired = 1'b0;

   delayed_task_dispatch_table u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_task_id       (req_task_id),
      .req_delay         (req_delay),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_fired         (rsp_fired),
      .rsp_fired_task    (rsp_fired_task),
      .rsp_cleared_count (rsp_cleared_count)
   );

   always #10 clock = ~clock;

   function automatic outcome_type apply_table_op(logic [1:0] op, logic [IW-1:0] id,
                                                  logic [DW-1:0] delay);
      outcome_type o;
      int i;
      int w;
      int hit;
      o = '{1'b0, 1'b0, '0, '0};
      case (op)
         OP_ADD: begin
            if (id != 0 && delay != 0 && shadow_count < DEPTH) begin
               shadow_task[shadow_count] = id;
               shadow_delay[shadow_count] = delay;
               shadow_count++;
               o.accepted = 1'b1;
            end
         end
         OP_CLEAR: begin
            w = 0;
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_task[i] == id) begin
                  o.cleared = o.cleared + 1'b1;
               end else begin
                  shadow_task[w] = shadow_task[i];
                  shadow_delay[w] = shadow_delay[i];
                  w++;
               end
            end
            shadow_count = w;
            o.accepted = 1'b1;
         end
         OP_TICK: begin
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_delay[i] != 0)
                  shadow_delay[i] = shadow_delay[i] - 1'b1;
               else
                  shadow_expired = 1'b1;
            end
            if (shadow_expired) begin
               hit = -1;
               for (i = 0; i < shadow_count; i++) begin
                  if (hit < 0 && shadow_delay[i] == 0)
                     hit = i;
               end
               if (hit >= 0) begin
                  o.fired = 1'b1;
                  o.fired_task = shadow_task[hit];
                  for (i = hit; i < shadow_count - 1; i++) begin
                     shadow_task[i] = shadow_task[i + 1];
                     shadow_delay[i] = shadow_delay[i + 1];
                  end
                  shadow_count--;
               end else begin
                  shadow_expired = 1'b0;
               end
            end
            o.accepted = 1'b1;
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic task_cmd_type mk_cmd(logic [1:0] op, logic [IW-1:0] id,
                                           logic [DW-1:0] delay, bit quiet);
      task_cmd_type c;
      c.op = op;
      c.id = id;
      c.delay = delay;
      c.quiet = quiet;
      return c;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch %s: expected %0d, actual %0d", name, exp_val, act_val);
      end
   endtask

   // drive request beats
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accept_cnt == req_issue_cnt) begin
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (task_cmd_q.size() != 0) begin
            drv_cmd = task_cmd_q.pop_front();
            req_operation <= drv_cmd.op;
            req_task_id <= drv_cmd.id;
            req_delay <= drv_cmd.delay;
            req_valid <= 1'b1;
            req_issue_cnt++;
            quiet_phase = drv_cmd.quiet;
            if (!drv_cmd.quiet && $urandom_range(0, 2) == 0)
               req_gap = $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // stall result beats in short bursts
   always @(negedge clock) begin
      if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (!reset && !quiet_phase && $urandom_range(0, 3) == 0) begin
         rsp_stall = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // check result beats, predict on request beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: result beat with nothing expected");
            end else begin
               want = outcome_q.pop_front();
               check_field("accepted", want.accepted, rsp_accepted);
               check_field("fired", want.fired, rsp_fired);
               check_field("fired_task", want.fired_task, rsp_fired_task);
               check_field("cleared_count", want.cleared, rsp_cleared_count);
            end
         end
         if (req_valid && req_ready) begin
            outcome_q.push_back(apply_table_op(req_operation, req_task_id, req_delay));
            req_accept_cnt++;
         end
      end
   end

   initial begin
      int seg;
      int k;
      int r;
      int mode;
      int add_lim;
      int clear_lim;
      int n;
      bit calm;
      logic [IW-1:0] id;
      logic [DW-1:0] delay;
      logic [IW-1:0] recent_ids [8];
      n = 0;
      for (k = 0; k < 8; k++)
         recent_ids[k] = k + 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      task_cmd_q.push_back(mk_cmd(OP_ADD, 8'd0, 16'd5, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_ADD, 8'd9, 16'd0, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_ADD, 8'd255, 16'hFFFF, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_ADD, 8'd1, 16'd1, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_CLEAR, 8'd0, 16'd0, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_UNUSED, 8'd255, 16'hFFFF, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_TICK, 8'd0, 16'd0, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_TICK, 8'd0, 16'd0, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_ADD, 8'd2, 16'd1, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_ADD, 8'd3, 16'd1, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_TICK, 8'd0, 16'd0, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_TICK, 8'd0, 16'd0, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_TICK, 8'd0, 16'd0, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_TICK, 8'd0, 16'd0, 1'b0));
      task_cmd_q.push_back(mk_cmd(OP_CLEAR, 8'd255, 16'd0, 1'b0));

      // hold off until the table has answered everything
      while (task_cmd_q.size() != 0 || req_accept_cnt != req_issue_cnt ||
             outcome_q.size() != 0)
         @(posedge clock);

      for (seg = 0; seg < 24; seg++) begin
         mode = $urandom_range(0, 2);
         calm = (seg >= 21) || ($urandom_range(0, 4) == 0);
         add_lim = (mode == 0) ? 60 : (mode == 1) ? 30 : 45;
         clear_lim = add_lim + ((mode == 2) ? 12 : 8);
         if (seg == 12) begin
            while (task_cmd_q.size() != 0 || req_accept_cnt != req_issue_cnt ||
                   outcome_q.size() != 0)
               @(posedge clock);
         end
         for (k = 0; k < 50; k++) begin
            r = $urandom_range(0, 99);
            if (r < add_lim) begin
               case ($urandom_range(0, 9))
                  0: id = '0;
                  1: id = $urandom_range(0, 255);
                  default: id = $urandom_range(1, 6);
               endcase
               case ($urandom_range(0, 19))
                  0: delay = '0;
                  1: delay = '1;
                  2, 3: delay = $urandom_range(0, 65535);
                  4, 5, 6, 7: delay = $urandom_range(6, 40);
                  default: delay = $urandom_range(1, 5);
               endcase
               if (id != 0) begin
                  recent_ids[n % 8] = id;
                  n++;
               end
               task_cmd_q.push_back(mk_cmd(OP_ADD, id, delay, calm));
            end else if (r < clear_lim) begin
               case ($urandom_range(0, 9))
                  0: id = '0;
                  1, 2, 3, 4: id = recent_ids[$urandom_range(0, 7)];
                  default: id = $urandom_range(1, 6);
               endcase
               task_cmd_q.push_back(mk_cmd(OP_CLEAR, id, $urandom_range(0, 65535), calm));
            end else if (r < 98) begin
               task_cmd_q.push_back(mk_cmd(OP_TICK, $urandom_range(0, 255),
                                           $urandom_range(0, 65535), calm));
            end else begin
               task_cmd_q.push_back(mk_cmd(OP_UNUSED, $urandom_range(0, 255),
                                           $urandom_range(0, 65535), calm));
            end
         end
         // fill the table past full with one identifier
         if ($urandom_range(0, 3) == 0) begin
            id = $urandom_range(1, 255);
            recent_ids[n % 8] = id;
            n++;
            for (k = 0; k <= DEPTH; k++)
               task_cmd_q.push_back(mk_cmd(OP_ADD, id, $urandom_range(1, 3), calm));
         end
      end

      while (task_cmd_q.size() != 0 || req_accept_cnt != req_issue_cnt ||
             outcome_q.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && outcome_q.size() == 0)
         $display("delayed_task_dispatch_table regression: pass");
      else
         $display("delayed_task_dispatch_table regression: fail");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("delayed_task_dispatch_table regression: fail");
      $finish;
   end

endmodule
